// File: hw/rtl/channel_mean_stddev_stats_unit_macros.svh
// Assertion macros used by the channel statistics back stage.
`ifndef CHANNEL_MEAN_STDDEV_STATS_UNIT_MACROS_SVH
`define CHANNEL_MEAN_STDDEV_STATS_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle; expects clk and rst in scope.
`define CMSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds at every edge out of reset.
`define CMSS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// File: hw/rtl/cmss_pkg.sv
// Shared types, widths and helpers for the channel statistics unit.
`timescale 1ns / 1ps
package cmss_pkg;
  localparam int MAX_CHANNELS = 4;
  localparam int COUNT_BITS   = 20;
  localparam int SAMPLE_BITS  = 16;
  localparam int CH_W   = 2;
  localparam int NCH_W  = 3;
  localparam int CNT_W  = COUNT_BITS + 1;
  localparam int SUM_W  = 37;
  localparam int MAG_W  = 36;
  localparam int SQ_W   = 51;
  localparam int SQS_W  = 32;
  localparam int WIDE_W = 72;
  localparam int DIVD_W = 42;
  localparam int STEP_W = 7;
  localparam logic [STEP_W-1:0] MUL_LAST  = 7'd36;
  localparam logic [STEP_W-1:0] DIV_LAST  = 7'd71;
  localparam logic [STEP_W-1:0] SQRT_LAST = 7'd15;
  localparam logic [CNT_W-1:0]  COUNT_LIMIT = CNT_W'(1) << COUNT_BITS;
  localparam logic [NCH_W-1:0]  CFG_RESET = 3'd3;

  typedef struct packed {
    logic                          active;
    logic [CH_W-1:0]               ch;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [SQS_W-1:0]              square;
    logic                          frame_end;
  } item_t;

  typedef enum logic [3:0] {
    S_ACC, S_LOAD, S_MUL_SQ, S_MUL_MM, S_MUL_CC,
    S_DIV_VAR, S_SQRT, S_DIV_MEAN, S_EMIT
  } back_state_t;

  // Clamp the register to the supported channel range.
  function automatic logic [NCH_W-1:0] active_count(input logic [NCH_W-1:0] v);
    if (v == '0) return NCH_W'(1);
    if (v > NCH_W'(MAX_CHANNELS)) return NCH_W'(MAX_CHANNELS);
    return v;
  endfunction
endpackage

// File: hw/rtl/cmss_ifs.sv
// Handshake channels of the channel statistics unit.
`timescale 1ns / 1ps
interface cmss_sample_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel_index;
  logic signed [15:0] sample_value;
  logic        frame_end;
  modport source (output valid, channel_index, sample_value, frame_end, input ready);
  modport sink (input valid, channel_index, sample_value, frame_end, output ready);
endinterface

interface cmss_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_channel;
  logic signed [15:0] mean_out;
  logic [15:0] deviation_out;
  logic        empty_flag;
  logic        overflow_flag;
  logic        last_result;
  modport source (output valid, result_channel, mean_out, deviation_out, empty_flag,
                  overflow_flag, last_result, input ready);
  modport sink (input valid, result_channel, mean_out, deviation_out, empty_flag,
                overflow_flag, last_result, output ready);
endinterface

interface cmss_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/cmss_front.sv
// Front stage: accept samples, mark active channels and square the sample.
`timescale 1ns / 1ps
module cmss_front (
  input  logic                      clk,
  input  logic                      rst,
  cmss_sample_if.sink               sample_in,
  input  logic [cmss_pkg::NCH_W-1:0] n_active,
  output cmss_pkg::item_t           item,
  output logic                      item_valid,
  input  logic                      item_ready
);
  import cmss_pkg::*;

  logic [SAMPLE_BITS-1:0] mag;
  logic                   take;

  assign sample_in.ready = !item_valid || item_ready;
  assign take = sample_in.valid && sample_in.ready;
  assign mag  = sample_in.sample_value[SAMPLE_BITS-1] ?
                SAMPLE_BITS'(-sample_in.sample_value) : sample_in.sample_value;

  // Hold the classified item until the queue takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.active    <= {1'b0, sample_in.channel_index} < n_active;
      item.ch        <= sample_in.channel_index;
      item.sample    <= sample_in.sample_value;
      item.square    <= SQS_W'(mag * mag);
      item.frame_end <= sample_in.frame_end;
    end
  end
endmodule

// File: hw/rtl/cmss_queue.sv
// Four-entry queue between the front and back stages.
`timescale 1ns / 1ps
module cmss_queue (
  input  logic            clk,
  input  logic            rst,
  input  cmss_pkg::item_t push_item,
  input  logic            push_valid,
  output logic            push_ready,
  output cmss_pkg::item_t pop_item,
  output logic            pop_valid,
  input  logic            pop
);
  import cmss_pkg::*;

  item_t      slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       push;

  assign push_ready = fill != 3'd4;
  assign push       = push_valid && push_ready;
  assign pop_valid  = fill != 3'd0;
  assign pop_item   = slots[rd_ptr];

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end
endmodule

// File: hw/rtl/cmss_back.sv
// Back stage: accumulate per channel, then compute mean and deviation serially.
`timescale 1ns / 1ps
`include "channel_mean_stddev_stats_unit_macros.svh"
module cmss_back (
  input  logic                       clk,
  input  logic                       rst,
  input  cmss_pkg::item_t            q_item,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  logic [cmss_pkg::NCH_W-1:0] n_active,
  cmss_result_if.source              result_out
);
  import cmss_pkg::*;

  logic signed [SUM_W-1:0] acc_sum [MAX_CHANNELS];
  logic [SQ_W-1:0]         acc_sq  [MAX_CHANNELS];
  logic [CNT_W-1:0]        acc_cnt [MAX_CHANNELS];
  logic                    acc_ovf [MAX_CHANNELS];

  back_state_t state, state_next;
  logic [CH_W-1:0]   k;
  logic [STEP_W-1:0] step;

  logic [CNT_W-1:0]  c_r;
  logic [MAG_W-1:0]  mag_r;
  logic              neg_r;
  logic              ovf_r;
  logic [WIDE_W-1:0] prod1;
  logic [WIDE_W-1:0] prod2;
  logic signed [15:0] mean_r;
  logic [15:0]       dev_r;

  logic [WIDE_W-1:0] mul_a, mul_acc, mul_acc_step;
  logic [MAG_W:0]    mul_b;
  logic [DIVD_W-1:0] div_d;
  logic [WIDE_W-1:0] div_dvd, div_dvd_step;
  logic [DIVD_W:0]   div_rem, div_rem_step, rem_sh;
  logic              div_ge;
  logic [31:0]       sq_x, sq_res, sq_bit, sq_t, sq_x_step, sq_res_step;
  logic              sq_ge;

  logic              emit;
  logic              is_last_ch;
  logic              mul_done, div_done, sqrt_done;
  logic [SUM_W-1:0]  sum_abs;
  logic [15:0]       q16, lim;

  // Control strobes from the state.
  always_comb begin
    q_pop      = (state == S_ACC) && q_valid;
    emit       = (state == S_EMIT) && (!result_out.valid || result_out.ready);
    mul_done   = step == MUL_LAST;
    div_done   = step == DIV_LAST;
    sqrt_done  = step == SQRT_LAST;
    is_last_ch = ({1'b0, k} + NCH_W'(1)) == n_active;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_ACC:      if (q_pop && q_item.frame_end) state_next = S_LOAD;
      S_LOAD:     state_next = (acc_cnt[k] == '0) ? S_EMIT : S_MUL_SQ;
      S_MUL_SQ:   if (mul_done) state_next = S_MUL_MM;
      S_MUL_MM:   if (mul_done) state_next = S_MUL_CC;
      S_MUL_CC:   if (mul_done) state_next = S_DIV_VAR;
      S_DIV_VAR:  if (div_done) state_next = S_SQRT;
      S_SQRT:     if (sqrt_done) state_next = S_DIV_MEAN;
      S_DIV_MEAN: if (div_done) state_next = S_EMIT;
      S_EMIT:     if (emit) state_next = is_last_ch ? S_ACC : S_LOAD;
      default:    state_next = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

  // Serial unit steps: shift-add multiply, restoring divide, digit root.
  always_comb begin
    mul_acc_step = mul_b[0] ? mul_acc + mul_a : mul_acc;
    rem_sh       = {div_rem[DIVD_W-1:0], div_dvd[WIDE_W-1]};
    div_ge       = rem_sh >= {1'b0, div_d};
    div_rem_step = div_ge ? rem_sh - {1'b0, div_d} : rem_sh;
    div_dvd_step = {div_dvd[WIDE_W-2:0], div_ge};
    sq_t         = sq_res + sq_bit;
    sq_ge        = sq_x >= sq_t;
    sq_x_step    = sq_ge ? sq_x - sq_t : sq_x;
    sq_res_step  = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
    sum_abs      = acc_sum[k][SUM_W-1] ? SUM_W'(-acc_sum[k]) : acc_sum[k];
    lim          = neg_r ? 16'h8000 : 16'h7fff;
    q16          = (|div_dvd_step[WIDE_W-1:16] || div_dvd_step[15:0] > lim) ?
                   lim : div_dvd_step[15:0];
  end

  // Step counter and channel index.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      k    <= '0;
    end else begin
      if (state != state_next) step <= '0;
      else step <= step + STEP_W'(1);
      if (state == S_ACC) k <= '0;
      else if (emit) k <= k + CH_W'(1);
    end
  end

  // Datapath of the report sequence.
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        c_r     <= acc_cnt[k];
        mag_r   <= sum_abs[MAG_W-1:0];
        neg_r   <= acc_sum[k][SUM_W-1];
        ovf_r   <= acc_ovf[k];
        mean_r  <= '0;
        dev_r   <= '0;
        mul_a   <= WIDE_W'(acc_sq[k]);
        mul_b   <= (MAG_W+1)'(acc_cnt[k]);
        mul_acc <= '0;
      end
      S_MUL_SQ, S_MUL_MM, S_MUL_CC: begin
        if (mul_done) begin
          mul_acc <= '0;
          if (state == S_MUL_SQ) begin
            prod1 <= mul_acc_step;
            mul_a <= WIDE_W'(mag_r);
            mul_b <= (MAG_W+1)'(mag_r);
          end else if (state == S_MUL_MM) begin
            prod2 <= mul_acc_step;
            mul_a <= WIDE_W'(c_r);
            mul_b <= (MAG_W+1)'(c_r);
          end else begin
            div_d   <= mul_acc_step[DIVD_W-1:0];
            div_dvd <= (prod1 > prod2) ? prod1 - prod2 : '0;
            div_rem <= '0;
          end
        end else begin
          mul_a   <= mul_a << 1;
          mul_b   <= mul_b >> 1;
          mul_acc <= mul_acc_step;
        end
      end
      S_DIV_VAR, S_DIV_MEAN: begin
        div_rem <= div_rem_step;
        div_dvd <= div_dvd_step;
        if (div_done && state == S_DIV_VAR) begin
          sq_x   <= |div_dvd_step[WIDE_W-1:32] ? 32'hffff_ffff : div_dvd_step[31:0];
          sq_res <= '0;
          sq_bit <= 32'h4000_0000;
        end
        if (div_done && state == S_DIV_MEAN) begin
          mean_r <= neg_r ? -q16 : q16;
        end
      end
      S_SQRT: begin
        sq_x   <= sq_x_step;
        sq_res <= sq_res_step;
        sq_bit <= sq_bit >> 2;
        if (sqrt_done) begin
          dev_r   <= |sq_res_step[31:16] ? 16'hffff : sq_res_step[15:0];
          div_d   <= DIVD_W'({c_r, 1'b0});
          div_dvd <= WIDE_W'({mag_r, 1'b0}) + WIDE_W'(c_r);
          div_rem <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Accumulate popped samples; clear all channels after the last result.
  always_ff @(posedge clk) begin
    if (rst || (emit && is_last_ch)) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        acc_sum[i] <= '0;
        acc_sq[i]  <= '0;
        acc_cnt[i] <= '0;
        acc_ovf[i] <= 1'b0;
      end
    end else if (q_pop && q_item.active) begin
      if (acc_cnt[q_item.ch] == COUNT_LIMIT) begin
        acc_ovf[q_item.ch] <= 1'b1;
      end else begin
        acc_sum[q_item.ch] <= acc_sum[q_item.ch] + SUM_W'(q_item.sample);
        acc_sq[q_item.ch]  <= acc_sq[q_item.ch] + SQ_W'(q_item.square);
        acc_cnt[q_item.ch] <= acc_cnt[q_item.ch] + CNT_W'(1);
      end
    end
  end

  // Output register: load on emit, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (emit) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_out.result_channel <= k;
      result_out.mean_out       <= mean_r;
      result_out.deviation_out  <= dev_r;
      result_out.empty_flag     <= c_r == '0;
      result_out.overflow_flag  <= ovf_r;
      result_out.last_result    <= is_last_ch;
    end
  end

  `CMSS_ASSERT_IMPL(a_pop_in_acc, q_pop, state == S_ACC, "pop outside accumulate")
  `CMSS_ASSERT_IMPL(a_empty_zero, result_out.valid && result_out.empty_flag,
                    result_out.mean_out == 0 && result_out.deviation_out == 0,
                    "empty channel with nonzero statistics")
  `CMSS_ASSERT_ALWAYS(a_count_cap, acc_cnt[0] <= COUNT_LIMIT, "sample count past limit")
  `CMSS_ASSERT_IMPL(a_emit_in_range, emit, {1'b0, k} < n_active, "result channel out of range")
endmodule

// File: hw/rtl/channel_mean_stddev_stats_unit.sv
// Top level of the per-channel mean and standard deviation unit.
`timescale 1ns / 1ps
// Accepts one sample per cycle, while the queue has room, into per-channel count, sum
// and sum-of-squares accumulators. A sample with frame_end closes the frame: for each
// active channel the unit runs one shared serial engine (three shift-add multiplies, a
// restoring divide for the variance, a square root and a divide for the rounded mean)
// and emits one result per channel in order, then clears the accumulators. During that
// time samples keep entering the front stage and four-entry queue until it fills. The
// user must write channels_in_use through cfg only while the unit is idle; the block
// itself does not enforce it.
module channel_mean_stddev_stats_unit (
  input  logic           clk,
  input  logic           rst,
  cmss_sample_if.sink    sample_in,
  cmss_result_if.source  result_out,
  cmss_cfg_if.sink       cfg
);
  import cmss_pkg::*;

  logic [NCH_W-1:0] channels_in_use;
  logic [NCH_W-1:0] n_active;
  item_t            f_item, q_item;
  logic             f_valid, f_ready, q_valid, q_pop;

  assign cfg.ready = 1'b1;
  assign n_active  = active_count(channels_in_use);

  // Channel count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CFG_RESET;
    end else if (cfg.valid) begin
      channels_in_use <= cfg.data;
    end
  end

  cmss_front u_front (
    .clk(clk), .rst(rst), .sample_in(sample_in), .n_active(n_active),
    .item(f_item), .item_valid(f_valid), .item_ready(f_ready)
  );

  cmss_queue u_queue (
    .clk(clk), .rst(rst), .push_item(f_item), .push_valid(f_valid),
    .push_ready(f_ready), .pop_item(q_item), .pop_valid(q_valid), .pop(q_pop)
  );

  cmss_back u_back (
    .clk(clk), .rst(rst), .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
    .n_active(n_active), .result_out(result_out)
  );
endmodule

// File: tb/channel_mean_stddev_stats_unit_tb.sv
// Self-checking testbench for the per-channel mean and standard deviation unit.
`timescale 1ns / 1ps
module channel_mean_stddev_stats_unit_tb;
  import cmss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 1500;
  localparam int FULL_COUNT = 1 << COUNT_BITS;

  typedef struct {
    logic [1:0]         ch;
    logic signed [15:0] mean;
    logic [15:0]        dev;
    logic               empty;
    logic               ovf;
    logic               last;
  } stats_t;

  typedef struct {
    logic [1:0]         ch;
    logic signed [15:0] val;
    logic               fe;
    logic               known;
    logic signed [15:0] mean;
    logic [15:0]        dev;
    logic               empty;
    logic               ovf;
  } row_t;

  logic clk;
  logic rst;
  int   errors;
  int   cycles;
  int   idle_pct;
  int   stall_pct;

  cmss_sample_if s_if ();
  cmss_result_if r_if ();
  cmss_cfg_if    c_if ();

  channel_mean_stddev_stats_unit dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (s_if),
    .result_out (r_if),
    .cfg        (c_if)
  );

  // Predictor state
  logic [2:0]  chan_reg;
  longint      acc_sum [MAX_CHANNELS];
  logic [63:0] acc_sq [MAX_CHANNELS];
  longint      acc_cnt [MAX_CHANNELS];
  logic        acc_ovf [MAX_CHANNELS];
  stats_t      stats_q [$];

  // Typed expectation for the first result of a directed row
  logic   typed_on;
  stats_t typed_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    s_if.valid = 1'b0;
    s_if.channel_index = '0;
    s_if.sample_value = '0;
    s_if.frame_end = 1'b0;
    r_if.ready = 1'b0;
    c_if.valid = 1'b0;
    c_if.data = '0;
    typed_on = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
  end

  function automatic int active_n();
    if (chan_reg == 3'd0) return 1;
    if (chan_reg > 3'(MAX_CHANNELS)) return MAX_CHANNELS;
    return int'(chan_reg);
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] v);
    logic [63:0]  r;
    logic [127:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = 128'(r | (64'd1 << b));
      if (t * t <= v) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  task automatic clear_accumulators();
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      acc_sum[k] = 0;
      acc_sq[k] = '0;
      acc_cnt[k] = 0;
      acc_ovf[k] = 1'b0;
    end
  endtask

  // Accumulate one sample; on frame end queue one statistics record per active channel.
  task automatic accumulate_sample(logic [1:0] ch, logic signed [15:0] val, logic fe);
    int           n;
    longint       s;
    longint       mag;
    longint       c;
    longint       q;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] var_v;
    logic [63:0]  dv;
    stats_t       r;
    n = active_n();
    s = longint'(val);
    if (int'(ch) < n) begin
      if (acc_cnt[ch] >= FULL_COUNT) begin
        acc_ovf[ch] = 1'b1;
      end else begin
        acc_sum[ch] += s;
        acc_sq[ch] += 64'(s * s);
        acc_cnt[ch] += 1;
      end
    end
    if (!fe) return;
    for (int k = 0; k < n; k++) begin
      c = acc_cnt[k];
      r.ch = 2'(k);
      r.mean = '0;
      r.dev = '0;
      r.empty = (c == 0);
      r.ovf = acc_ovf[k];
      r.last = (k + 1 == n);
      if (c != 0) begin
        mag = acc_sum[k] < 0 ? -acc_sum[k] : acc_sum[k];
        q = (2 * mag + c) / (2 * c);
        if (q > 32767 + (acc_sum[k] < 0 ? 1 : 0)) q = 32767 + (acc_sum[k] < 0 ? 1 : 0);
        r.mean = 16'(acc_sum[k] < 0 ? -q : q);
        a = 128'(c) * 128'(acc_sq[k]);
        b = 128'(mag) * 128'(mag);
        var_v = (a <= b) ? '0 : (a - b) / (128'(c) * 128'(c));
        dv = floor_root(var_v);
        r.dev = (dv > 64'hFFFF) ? 16'hFFFF : dv[15:0];
      end
      if (k == 0 && typed_on) begin
        r.mean = typed_res.mean;
        r.dev = typed_res.dev;
        r.empty = typed_res.empty;
        r.ovf = typed_res.ovf;
      end
      stats_q.push_back(r);
    end
    clear_accumulators();
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Track accepted transfers at the rising edge
  always @(posedge clk) begin
    stats_t e;
    if (rst) begin
      chan_reg <= CFG_RESET;
      clear_accumulators();
    end else begin
      if (c_if.valid && c_if.ready) chan_reg = c_if.data;
      if (s_if.valid && s_if.ready)
        accumulate_sample(s_if.channel_index, s_if.sample_value, s_if.frame_end);
      if (r_if.valid && r_if.ready) begin
        if (stats_q.size() == 0) begin
          report("unexpected result channel", r_if.result_channel, -1);
        end else begin
          e = stats_q.pop_front();
          if (r_if.result_channel !== e.ch) report("channel", r_if.result_channel, e.ch);
          if (r_if.mean_out !== e.mean) report("mean", r_if.mean_out, e.mean);
          if (r_if.deviation_out !== e.dev) report("deviation", r_if.deviation_out, e.dev);
          if (r_if.empty_flag !== e.empty) report("empty", r_if.empty_flag, e.empty);
          if (r_if.overflow_flag !== e.ovf) report("overflow", r_if.overflow_flag, e.ovf);
          if (r_if.last_result !== e.last) report("last", r_if.last_result, e.last);
        end
      end
    end
  end

  // Run timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (!rst) r_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send(logic [1:0] ch, logic signed [15:0] val, logic fe);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    s_if.valid <= 1'b1;
    s_if.channel_index <= ch;
    s_if.sample_value <= val;
    s_if.frame_end <= fe;
    @(posedge clk);
    while (!s_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic go_idle();
    s_if.valid <= 1'b0;
    typed_on = 1'b0;
    @(negedge clk);
    while (stats_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] v);
    c_if.valid <= 1'b1;
    c_if.data <= v;
    @(posedge clk);
    while (!c_if.ready) @(posedge clk);
    @(negedge clk);
    c_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'sh7FFF;
    if (pick == 1) return 16'sh8000;
    if (pick < 5) return 16'($urandom_range(511)) - 16'sd256;
    return 16'($urandom);
  endfunction

  row_t rows [] = '{
    '{2'd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 16'd0, 1'b0, 1'b0},
    '{2'd3, 16'sd100, 1'b1, 1'b1, 16'sd0, 16'd0, 1'b1, 1'b0},
    '{2'd0, 16'sh7FFF, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0},
    '{2'd0, 16'sh8000, 1'b1, 1'b1, -16'sd1, 16'd32767, 1'b0, 1'b0},
    '{2'd1, 16'sh8000, 1'b1, 1'b1, 16'sd0, 16'd0, 1'b1, 1'b0},
    '{2'd0, 16'sh8000, 1'b1, 1'b1, 16'sh8000, 16'd0, 1'b0, 1'b0},
    '{2'd0, 16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 16'd0, 1'b0, 1'b0},
    '{2'd0, 16'sd1, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0},
    '{2'd0, 16'sd2, 1'b1, 1'b1, 16'sd2, 16'd0, 1'b0, 1'b0},
    '{2'd0, -16'sd1, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0},
    '{2'd0, -16'sd2, 1'b1, 1'b1, -16'sd2, 16'd0, 1'b0, 1'b0},
    '{2'd1, 16'sd1234, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0},
    '{2'd2, -16'sd555, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0},
    '{2'd1, -16'sd7, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0},
    '{2'd3, 16'sh5555, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0},
    '{2'd2, 16'sh2AAA, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0},
    '{2'd0, 16'shD555, 1'b0, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0},
    '{2'd2, 16'sd9999, 1'b1, 1'b0, 16'sd0, 16'd0, 1'b0, 1'b0}
  };

  logic [2:0] cfg_plan [] = '{3'd3, 3'd0, 3'd7, 3'd4, 3'd1, 3'd2, 3'd5};

  initial begin
    int n;
    int per_phase;
    logic [1:0] ch;
    errors = 0;
    cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows at the reset setting
    foreach (rows[i]) begin
      typed_on = rows[i].known;
      typed_res.mean = rows[i].mean;
      typed_res.dev = rows[i].dev;
      typed_res.empty = rows[i].empty;
      typed_res.ovf = rows[i].ovf;
      send(rows[i].ch, rows[i].val, rows[i].fe);
    end
    go_idle();

    // Register change with a frame half accumulated
    write_cfg(3'd4);
    send(2'd3, 16'sd300, 1'b0);
    send(2'd2, -16'sd40, 1'b0);
    go_idle();
    write_cfg(3'd2);
    send(2'd0, 16'sd8, 1'b1);
    go_idle();

    // Random phases across settings and idling modes
    per_phase = 44;
    foreach (cfg_plan[p]) begin
      write_cfg(cfg_plan[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      n = (cfg_plan[p] == 3'd0) ? 1 : (cfg_plan[p] > 3'd4 ? 4 : int'(cfg_plan[p]));
      for (int i = 0; i < per_phase; i++) begin
        ch = ($urandom_range(9) == 0) ? 2'($urandom) : 2'($urandom_range(n - 1));
        send(ch, rand_sample(), (i == per_phase - 1) || ($urandom_range(7) == 0));
        // Hold the sender until every pending result is back
        if (p == 2 && i == per_phase / 2) begin
          s_if.valid <= 1'b0;
          @(negedge clk);
          while (stats_q.size() != 0) @(negedge clk);
        end
      end
      go_idle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
